// File: hw/rtl/emcs_pkg.sv
// shared types, constants and opcode tables of the motion command sequencer
`timescale 1ns / 1ps

package emcs_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int COUNT_BITS  = 16;
    localparam int TABLE_AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // step index and program length share the 7 bit current_step width
    localparam int STEP_W  = 7;
    localparam int STEP_CAP = (TABLE_DEPTH < 127) ? TABLE_DEPTH : 127;

    localparam int DUTY_W  = 10;
    localparam int TGT_W   = 16;
    localparam int ECHO_W  = 16;

    localparam logic [ECHO_W-1:0] NEAR_LIMIT_RESET = 16'd1755;

    // configuration register indexes
    localparam logic CFG_PROGRAM_LENGTH = 1'b0;
    localparam logic CFG_NEAR_LIMIT     = 1'b1;

    // request kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    // opcodes
    localparam logic [2:0] OP_LINE       = 3'd0;
    localparam logic [2:0] OP_LEFT       = 3'd1;
    localparam logic [2:0] OP_RIGHT      = 3'd2;
    localparam logic [2:0] OP_BACK_RIGHT = 3'd3;
    localparam logic [2:0] OP_BACK_LEFT  = 3'd4;
    localparam logic [2:0] OP_BACK       = 3'd5;
    localparam logic [2:0] OP_FAST_LINE  = 3'd6;
    localparam logic [2:0] OP_STOP       = 3'd7;

    // bridge pins, bit 0 is in1 .. bit 3 is in4
    localparam logic [3:0] PIN_L_FWD  = 4'b0010;
    localparam logic [3:0] PIN_L_REV  = 4'b0001;
    localparam logic [3:0] PIN_R_FWD  = 4'b1000;
    localparam logic [3:0] PIN_R_REV  = 4'b0100;
    localparam logic [3:0] PINS_RESET = 4'b0101;
    localparam logic [3:0] PINS_BRAKE = 4'b1111;

    localparam logic [DUTY_W-1:0] DUTY_SLOW = 10'd512;
    localparam logic [DUTY_W-1:0] DUTY_NORM = 10'd700;
    localparam logic [DUTY_W-1:0] DUTY_TURN = 10'd800;
    localparam logic [DUTY_W-1:0] DUTY_FAST = 10'd900;

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [STEP_W-1:0]     t_step;
    typedef logic [TABLE_AW-1:0]   t_slot;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [TGT_W-1:0] left_target;
        logic [TGT_W-1:0] right_target;
    } t_cmd;

    typedef struct packed {
        logic [DUTY_W-1:0] left_duty;
        logic [DUTY_W-1:0] right_duty;
        logic [3:0]        left_pins;
        logic [3:0]        right_pins;
    } t_op_drive;

    function automatic t_op_drive f_op_drive(input logic [2:0] op);
        t_op_drive d;
        d = '{DUTY_NORM, DUTY_NORM, PIN_L_FWD | PIN_R_FWD, PIN_L_FWD | PIN_R_FWD};
        unique case (op)
            OP_LINE:       d = '{DUTY_NORM, DUTY_NORM, PIN_L_FWD | PIN_R_FWD,
                                 PIN_L_FWD | PIN_R_FWD};
            OP_LEFT:       d = '{DUTY_SLOW, DUTY_TURN, PIN_L_FWD | PIN_R_FWD,
                                 PIN_L_FWD | PIN_R_FWD};
            OP_RIGHT:      d = '{DUTY_TURN, DUTY_SLOW, PIN_L_FWD | PIN_R_FWD,
                                 PIN_L_FWD | PIN_R_FWD};
            OP_BACK_RIGHT: d = '{DUTY_NORM, DUTY_NORM, PIN_L_REV | PIN_R_FWD,
                                 PIN_L_REV | PIN_R_FWD};
            OP_BACK_LEFT:  d = '{DUTY_SLOW, DUTY_SLOW, PIN_L_REV | PIN_R_FWD,
                                 PIN_L_REV | PIN_R_REV};
            OP_BACK:       d = '{DUTY_NORM, DUTY_NORM, PIN_L_REV | PIN_R_REV,
                                 PIN_L_REV | PIN_R_REV};
            OP_FAST_LINE:  d = '{DUTY_FAST, DUTY_FAST, PIN_L_FWD | PIN_R_FWD,
                                 PIN_L_FWD | PIN_R_FWD};
            // stop is handled apart, the table entry is not used
            OP_STOP:       d = '{'0, '0, PINS_BRAKE, PINS_BRAKE};
            default:       d = '{'0, '0, PINS_BRAKE, PINS_BRAKE};
        endcase
        return d;
    endfunction

    // table slot of a step index (the index is below the depth when used)
    function automatic t_slot f_step_slot(input t_step s);
        logic [31:0] w;
        w = 32'(s);
        return w[TABLE_AW-1:0];
    endfunction

    function automatic t_slot f_entry_slot(input logic [5:0] e);
        logic [31:0] w;
        w = 32'(e);
        return w[TABLE_AW-1:0];
    endfunction

endpackage

// File: hw/rtl/emcs_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module emcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/encoder_motion_command_sequencer_unit.sv
// two-wheel motion command sequencer: command table, encoder counts, obstacle hold
// latency: a request's result is valid in the cycle after the request is accepted
// throughput: one request per unstalled cycle; the table read is registered and
// always addresses the next step index, with a write bypass for the same slot
// reset (synchronous, active low) clears step, counts, flags, duties, obstacle
// and sets in1 and in3 high; the command table is not cleared
`timescale 1ns / 1ps

module encoder_motion_command_sequencer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [5:0]  i_entry_index,
    input  logic [2:0]  i_entry_opcode,
    input  logic [15:0] i_entry_left_target,
    input  logic [15:0] i_entry_right_target,
    input  logic        i_left_pulse,
    input  logic        i_right_pulse,
    input  logic        i_echo_valid,
    input  logic [15:0] i_echo_ticks,

    output logic        o_valid,
    input  logic        i_stall,
    output logic [9:0]  o_left_duty,
    output logic [9:0]  o_right_duty,
    output logic        o_bridge_in1,
    output logic        o_bridge_in2,
    output logic        o_bridge_in3,
    output logic        o_bridge_in4,
    output logic [6:0]  o_current_step,
    output logic        o_program_done,
    output logic        o_obstacle_hold,
    output logic        o_servo_long_pulse
);

    import emcs_pkg::*;

    // configuration
    t_step             r_len;
    logic [ECHO_W-1:0] r_near_limit;

    // sequencer state, also the held result
    t_step             r_step,   n_step;
    t_count            r_lcnt,   n_lcnt;
    t_count            r_rcnt,   n_rcnt;
    logic              r_lreach, n_lreach;
    logic              r_rreach, n_rreach;
    logic [DUTY_W-1:0] r_lduty,  n_lduty;
    logic [DUTY_W-1:0] r_rduty,  n_rduty;
    logic [3:0]        r_pins,   n_pins;
    logic              r_near,   n_near;
    logic              r_out_valid;
    logic              r_done,   n_done;
    logic              r_hold,   n_hold;

    // table access
    logic      accept;
    logic      tbl_we;
    t_slot     tbl_waddr;
    t_slot     tbl_raddr;
    t_cmd      tbl_wdata;
    t_cmd      tbl_rdata;
    t_cmd      cur_cmd;
    logic      r_byp;
    t_cmd      r_byp_data;
    t_step     eff_len;
    t_op_drive drive;
    logic      lhit;
    logic      rhit;

    assign o_stall = r_out_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    assign eff_len = (r_len < STEP_CAP[STEP_W-1:0]) ? r_len : STEP_CAP[STEP_W-1:0];

    assign tbl_we    = accept && (i_kind == KIND_LOAD) && (32'(i_entry_index) < TABLE_DEPTH);
    assign tbl_waddr = f_entry_slot(i_entry_index);
    assign tbl_wdata = '{i_entry_opcode, i_entry_left_target, i_entry_right_target};
    assign tbl_raddr = f_step_slot(n_step);

    emcs_ram #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    // a write into the slot being read is missed by the ram's registered read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else begin
            r_byp <= tbl_we && (tbl_waddr == tbl_raddr);
        end
        r_byp_data <= tbl_wdata;
    end

    assign cur_cmd = r_byp ? r_byp_data : tbl_rdata;
    assign drive   = f_op_drive(cur_cmd.opcode);

    always_comb begin
        n_step   = r_step;
        n_lcnt   = r_lcnt;
        n_rcnt   = r_rcnt;
        n_lreach = r_lreach;
        n_rreach = r_rreach;
        n_lduty  = r_lduty;
        n_rduty  = r_rduty;
        n_pins   = r_pins;
        n_near   = r_near;
        lhit     = 1'b0;
        rhit     = 1'b0;
        if (accept && i_kind == KIND_STEP) begin
            if (i_left_pulse && r_lcnt != '1) begin
                n_lcnt = r_lcnt + 1'b1;
            end
            if (i_right_pulse && r_rcnt != '1) begin
                n_rcnt = r_rcnt + 1'b1;
            end
            if (i_echo_valid) begin
                n_near = i_echo_ticks < r_near_limit;
            end
            lhit = 32'(n_lcnt) >= 32'(cur_cmd.left_target);
            rhit = 32'(n_rcnt) >= 32'(cur_cmd.right_target);
            if (r_step < eff_len) begin
                if (n_near) begin
                    n_lduty = '0;
                    n_rduty = '0;
                end else if (cur_cmd.opcode == OP_STOP) begin
                    // brake: all pins high, reached flags are left alone
                    n_lduty = '0;
                    n_rduty = '0;
                    n_pins  = PINS_BRAKE;
                    n_lcnt  = '0;
                    n_rcnt  = '0;
                    n_step  = r_step + 1'b1;
                end else begin
                    if (lhit) begin
                        n_lduty  = '0;
                        n_lreach = 1'b1;
                    end else begin
                        n_lduty = drive.left_duty;
                        n_pins  = drive.left_pins;
                    end
                    // right call wins over the left one
                    if (rhit) begin
                        n_rduty  = '0;
                        n_rreach = 1'b1;
                    end else begin
                        n_rduty = drive.right_duty;
                        n_pins  = drive.right_pins;
                    end
                    if (n_lreach && n_rreach) begin
                        n_lreach = 1'b0;
                        n_rreach = 1'b0;
                        n_lcnt   = '0;
                        n_rcnt   = '0;
                        n_step   = r_step + 1'b1;
                    end
                end
            end
        end
        n_done = n_step >= eff_len;
        n_hold = n_near && !n_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len        <= '0;
            r_near_limit <= NEAR_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PROGRAM_LENGTH: r_len        <= i_cfg_data[STEP_W-1:0];
                CFG_NEAR_LIMIT:     r_near_limit <= i_cfg_data[ECHO_W-1:0];
                default:            r_len        <= r_len;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_lcnt      <= '0;
            r_rcnt      <= '0;
            r_lreach    <= 1'b0;
            r_rreach    <= 1'b0;
            r_lduty     <= '0;
            r_rduty     <= '0;
            r_pins      <= PINS_RESET;
            r_near      <= 1'b0;
            r_out_valid <= 1'b0;
            r_done      <= 1'b0;
            r_hold      <= 1'b0;
        end else begin
            if (accept) begin
                r_step      <= n_step;
                r_lcnt      <= n_lcnt;
                r_rcnt      <= n_rcnt;
                r_lreach    <= n_lreach;
                r_rreach    <= n_rreach;
                r_lduty     <= n_lduty;
                r_rduty     <= n_rduty;
                r_pins      <= n_pins;
                r_near      <= n_near;
                r_done      <= n_done;
                r_hold      <= n_hold;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid            = r_out_valid;
    assign o_left_duty        = r_lduty;
    assign o_right_duty       = r_rduty;
    assign o_bridge_in1       = r_pins[0];
    assign o_bridge_in2       = r_pins[1];
    assign o_bridge_in3       = r_pins[2];
    assign o_bridge_in4       = r_pins[3];
    assign o_current_step     = r_step;
    assign o_program_done     = r_done;
    assign o_obstacle_hold    = r_hold;
    assign o_servo_long_pulse = r_hold;

endmodule

// File: dv/tb_encoder_motion_command_sequencer_unit.sv
// self-checking testbench of the encoder motion command sequencer: random requests, scoreboard
`timescale 1ns / 1ps

module tb_encoder_motion_command_sequencer_unit;

    import emcs_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int PRE_STEPS    = 120;
    localparam int LONG_HOLD    = 300;
    localparam int SMALL_TARGET = 16;

    typedef struct packed {
        logic        kind;
        logic [5:0]  slot;
        logic [2:0]  opcode;
        logic [15:0] left_tgt;
        logic [15:0] right_tgt;
        logic        left_pulse;
        logic        right_pulse;
        logic        echo_valid;
        logic [15:0] echo_ticks;
    } motion_req_t;

    typedef struct packed {
        logic [9:0] left_duty;
        logic [9:0] right_duty;
        logic [3:0] pins;
        logic [6:0] step;
        logic       done;
        logic       hold;
        logic       servo;
    } motion_res_t;

    localparam int REQ_W = $bits(motion_req_t);

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = CFG_PROGRAM_LENGTH;
    logic [15:0] cfg_data  = '0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    motion_req_t drv       = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [9:0]  res_left_duty;
    logic [9:0]  res_right_duty;
    logic        res_in1, res_in2, res_in3, res_in4;
    logic [6:0]  res_step;
    logic        res_done;
    logic        res_hold;
    logic        res_servo;

    // sequencer state as predicted
    t_cmd        cmd_table [TABLE_DEPTH];
    int          step_idx      = 0;
    logic [15:0] left_cnt      = '0;
    logic [15:0] right_cnt     = '0;
    logic        left_reached  = 1'b0;
    logic        right_reached = 1'b0;
    logic [9:0]  duty_l        = '0;
    logic [9:0]  duty_r        = '0;
    logic [3:0]  pins          = PINS_RESET;
    logic        near_f        = 1'b0;
    logic [6:0]  cfg_len       = '0;
    logic [15:0] cfg_limit     = NEAR_LIMIT_RESET;

    motion_req_t pending_req_q [$];
    motion_res_t expected_motion_q [$];
    bit          slot_ready [TABLE_DEPTH];

    idle_mode_t  idle_mode      = IDLE_NONE;
    bit          long_hold_req  = 1'b0;
    bit          long_hold_done = 1'b0;
    int          hold_left      = 0;
    int          issued_n       = 0;
    int          checked_n      = 0;
    int          holds_seen     = 0;
    int          err_cnt        = 0;
    int          cycle_cnt      = 0;
    motion_res_t got;
    motion_res_t want;

    encoder_motion_command_sequencer_unit dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_cfg_we             (cfg_we),
        .i_cfg_index          (cfg_index),
        .i_cfg_data           (cfg_data),
        .i_valid              (req_valid),
        .o_stall              (req_stall),
        .i_kind               (drv.kind),
        .i_entry_index        (drv.slot),
        .i_entry_opcode       (drv.opcode),
        .i_entry_left_target  (drv.left_tgt),
        .i_entry_right_target (drv.right_tgt),
        .i_left_pulse         (drv.left_pulse),
        .i_right_pulse        (drv.right_pulse),
        .i_echo_valid         (drv.echo_valid),
        .i_echo_ticks         (drv.echo_ticks),
        .o_valid              (res_valid),
        .i_stall              (res_stall),
        .o_left_duty          (res_left_duty),
        .o_right_duty         (res_right_duty),
        .o_bridge_in1         (res_in1),
        .o_bridge_in2         (res_in2),
        .o_bridge_in3         (res_in3),
        .o_bridge_in4         (res_in4),
        .o_current_step       (res_step),
        .o_program_done       (res_done),
        .o_obstacle_hold      (res_hold),
        .o_servo_long_pulse   (res_servo)
    );

    always #4 clk = ~clk;

    // applies one accepted request to the predicted state, returns the expected outputs
    function automatic motion_res_t advance_sequencer(input motion_req_t r);
        motion_res_t res;
        t_cmd        c;
        logic [9:0]  dl, dr;
        logic [3:0]  pl, pr;
        int          eff_len;
        eff_len = (cfg_len < TABLE_DEPTH) ? int'(cfg_len) : TABLE_DEPTH;
        if (r.kind == KIND_LOAD) begin
            cmd_table[r.slot] = '{r.opcode, r.left_tgt, r.right_tgt};
        end else begin
            if (r.left_pulse && left_cnt != 16'hFFFF) left_cnt++;
            if (r.right_pulse && right_cnt != 16'hFFFF) right_cnt++;
            if (r.echo_valid) near_f = r.echo_ticks < cfg_limit;
            if (step_idx < eff_len) begin
                c = cmd_table[step_idx % TABLE_DEPTH];
                if (near_f) begin
                    duty_l = '0;
                    duty_r = '0;
                end else if (c.opcode == OP_STOP) begin
                    // brake: counts clear, reached flags are left alone
                    duty_l    = '0;
                    duty_r    = '0;
                    pins      = PINS_BRAKE;
                    left_cnt  = '0;
                    right_cnt = '0;
                    step_idx++;
                end else begin
                    dl = DUTY_NORM;
                    dr = DUTY_NORM;
                    pl = PIN_L_FWD | PIN_R_FWD;
                    pr = PIN_L_FWD | PIN_R_FWD;
                    case (c.opcode)
                        OP_LEFT: begin
                            dl = DUTY_SLOW;
                            dr = DUTY_TURN;
                        end
                        OP_RIGHT: begin
                            dl = DUTY_TURN;
                            dr = DUTY_SLOW;
                        end
                        OP_BACK_RIGHT: begin
                            pl = PIN_L_REV | PIN_R_FWD;
                            pr = PIN_L_REV | PIN_R_FWD;
                        end
                        OP_BACK_LEFT: begin
                            dl = DUTY_SLOW;
                            dr = DUTY_SLOW;
                            pl = PIN_L_REV | PIN_R_FWD;
                            pr = PIN_L_REV | PIN_R_REV;
                        end
                        OP_BACK: begin
                            pl = PIN_L_REV | PIN_R_REV;
                            pr = PIN_L_REV | PIN_R_REV;
                        end
                        OP_FAST_LINE: begin
                            dl = DUTY_FAST;
                            dr = DUTY_FAST;
                        end
                        default: begin
                        end
                    endcase
                    if (left_cnt >= c.left_target) begin
                        duty_l       = '0;
                        left_reached = 1'b1;
                    end else begin
                        duty_l = dl;
                        pins   = pl;
                    end
                    // the right wheel's direction call wins
                    if (right_cnt >= c.right_target) begin
                        duty_r        = '0;
                        right_reached = 1'b1;
                    end else begin
                        duty_r = dr;
                        pins   = pr;
                    end
                    if (left_reached && right_reached) begin
                        left_reached  = 1'b0;
                        right_reached = 1'b0;
                        left_cnt      = '0;
                        right_cnt     = '0;
                        step_idx++;
                    end
                end
            end
        end
        res.left_duty  = duty_l;
        res.right_duty = duty_r;
        res.pins       = pins;
        res.step       = 7'(step_idx);
        res.done       = step_idx >= eff_len;
        res.hold       = near_f && !res.done;
        res.servo      = res.hold;
        return res;
    endfunction

    task automatic flag_field(input string name, input logic [15:0] exp_v,
                              input logic [15:0] act_v);
        if (act_v !== exp_v) begin
            err_cnt++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endtask

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
        end else begin
            if (req_valid && !req_stall) begin
                expected_motion_q.push_back(advance_sequencer(drv));
            end
            if (!req_valid || !req_stall) begin
                if (pending_req_q.size() > 0 &&
                    !((idle_mode == IDLE_SENDER && $urandom_range(0, 99) < 68) ||
                      (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 30))) begin
                    drv       <= pending_req_q.pop_front();
                    req_valid <= 1'b1;
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // result side stall, with one long hold-off on request
    always @(posedge clk) begin
        if (!rst_n) begin
            res_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            res_stall <= 1'b1;
        end else if (long_hold_req && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD;
            res_stall     <= 1'b1;
        end else begin
            res_stall <= (idle_mode == IDLE_RECEIVER && $urandom_range(0, 99) < 68) ||
                         (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 30);
        end
    end

    // result monitor
    always @(posedge clk) begin
        if (rst_n && res_valid && !res_stall) begin
            got = '{res_left_duty, res_right_duty, {res_in4, res_in3, res_in2, res_in1},
                    res_step, res_done, res_hold, res_servo};
            if (expected_motion_q.size() == 0) begin
                err_cnt++;
                $display("%0t ns: result with none expected, got step %0d", $time, got.step);
            end else begin
                want = expected_motion_q.pop_front();
                flag_field("left_duty", 16'(want.left_duty), 16'(got.left_duty));
                flag_field("right_duty", 16'(want.right_duty), 16'(got.right_duty));
                flag_field("bridge_in1", 16'(want.pins[0]), 16'(got.pins[0]));
                flag_field("bridge_in2", 16'(want.pins[1]), 16'(got.pins[1]));
                flag_field("bridge_in3", 16'(want.pins[2]), 16'(got.pins[2]));
                flag_field("bridge_in4", 16'(want.pins[3]), 16'(got.pins[3]));
                flag_field("current_step", 16'(want.step), 16'(got.step));
                flag_field("program_done", 16'(want.done), 16'(got.done));
                flag_field("obstacle_hold", 16'(want.hold), 16'(got.hold));
                flag_field("servo_long_pulse", 16'(want.servo), 16'(got.servo));
                if (want.hold) holds_seen++;
                checked_n++;
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d results seen",
                     cycle_cnt, checked_n, issued_n);
            $display("FAIL encoder_motion_command_sequencer_unit");
            $finish;
        end
    end

    task automatic push_request(input motion_req_t r);
        pending_req_q.push_back(r);
        issued_n++;
    endtask

    task automatic push_load(input int slot, input logic [2:0] op, input logic [15:0] lt,
                             input logic [15:0] rt, input bit runnable);
        motion_req_t r;
        r           = '0;
        r.kind      = KIND_LOAD;
        r.slot      = 6'(slot);
        r.opcode    = op;
        r.left_tgt  = lt;
        r.right_tgt = rt;
        slot_ready[slot] = runnable;
        push_request(r);
    endtask

    task automatic push_step(input bit lp, input bit rp, input bit ev, input logic [15:0] ticks);
        motion_req_t r;
        r             = '0;
        r.kind        = KIND_STEP;
        r.left_pulse  = lp;
        r.right_pulse = rp;
        r.echo_valid  = ev;
        r.echo_ticks  = ticks;
        push_request(r);
    endtask

    task automatic wait_drained();
        while (checked_n != issued_n) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_PROGRAM_LENGTH) cfg_len = val[6:0];
        else cfg_limit = val;
    endtask

    // mostly steps with random pulses and sparse echoes, some table rewrites
    task automatic push_random_request(input int len, input int s0);
        motion_req_t r;
        r = motion_req_t'(REQ_W'({$urandom(), $urandom()}));
        if ($urandom_range(0, 99) < 15) begin
            r.kind = KIND_LOAD;
            if (len < TABLE_DEPTH && $urandom_range(0, 3) == 0) begin
                // full range targets only where the current program cannot reach
                r.slot = 6'($urandom_range(len, TABLE_DEPTH - 1));
                slot_ready[r.slot] = 1'b0;
            end else begin
                r.slot = (s0 < len) ? 6'($urandom_range(s0, len - 1))
                                    : 6'($urandom_range(0, TABLE_DEPTH - 1));
                r.left_tgt  = 16'($urandom_range(0, SMALL_TARGET));
                r.right_tgt = 16'($urandom_range(0, SMALL_TARGET));
                slot_ready[r.slot] = 1'b1;
            end
        end else begin
            r.kind        = KIND_STEP;
            r.left_pulse  = $urandom_range(0, 99) < 55;
            r.right_pulse = $urandom_range(0, 99) < 55;
            r.echo_valid  = $urandom_range(0, 99) < 8;
            if (r.echo_valid) begin
                case ($urandom_range(0, 5))
                    0: r.echo_ticks = cfg_limit - 16'd1;
                    1: r.echo_ticks = cfg_limit;
                    2: r.echo_ticks = cfg_limit + 16'd1;
                    3: r.echo_ticks = '0;
                    4: r.echo_ticks = 16'hFFFF;
                    default: r.echo_ticks = 16'($urandom_range(0, 65535));
                endcase
            end
        end
        push_request(r);
    endtask

    task automatic run_phase(input idle_mode_t mode, input int len, input logic [15:0] limit,
                             input int count, input bit pressure);
        int s0;
        wait_drained();
        idle_mode = IDLE_NONE;
        // every slot the program can reach holds a short command before the length goes up
        for (int i = 0; i < len; i++) begin
            if (!slot_ready[i]) begin
                push_load(i, 3'($urandom_range(0, 7)), 16'($urandom_range(0, SMALL_TARGET)),
                          16'($urandom_range(0, SMALL_TARGET)), 1'b1);
            end
        end
        wait_drained();
        cfg_write(CFG_NEAR_LIMIT, limit);
        cfg_write(CFG_PROGRAM_LENGTH, 16'(len));
        idle_mode = mode;
        s0 = step_idx;
        if (pressure) long_hold_req = 1'b1;
        for (int i = 0; i < count; i++) begin
            // sender pause until the pipe is empty
            if (pressure && i == count / 2) wait_drained();
            push_random_request(len, s0);
        end
    endtask

    initial begin
        motion_req_t r;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // counts keep rising while the program is done
        for (int i = 0; i < PRE_STEPS; i++) push_step(1'b1, 1'b1, 1'b0, '0);
        push_load(0, OP_LINE, 16'(PRE_STEPS), 16'(PRE_STEPS), 1'b1);
        wait_drained();
        cfg_write(CFG_PROGRAM_LENGTH, 16'd1);
        push_step(1'b0, 1'b0, 1'b1, 16'hFFFF);
        wait_drained();

        // one entry per opcode, then run them through obstacle holds
        push_load(1, OP_LINE, 16'd2, 16'd0, 1'b1);
        push_load(2, OP_LEFT, 16'd1, 16'd1, 1'b1);
        push_load(3, OP_RIGHT, 16'd0, 16'd3, 1'b1);
        push_load(4, OP_BACK_RIGHT, 16'd2, 16'd1, 1'b1);
        push_load(5, OP_BACK_LEFT, 16'd1, 16'd2, 1'b1);
        push_load(6, OP_BACK, 16'd1, 16'd1, 1'b1);
        push_load(7, OP_FAST_LINE, 16'd1, 16'd0, 1'b1);
        push_load(8, OP_STOP, 16'd0, 16'd0, 1'b1);
        // last slot, every field at its top, step fields set but ignored on a load
        r      = '1;
        r.kind = KIND_LOAD;
        slot_ready[TABLE_DEPTH - 1] = 1'b0;
        push_request(r);
        wait_drained();
        cfg_write(CFG_NEAR_LIMIT, NEAR_LIMIT_RESET);
        cfg_write(CFG_PROGRAM_LENGTH, 16'd9);
        push_step(1'b1, 1'b1, 1'b1, NEAR_LIMIT_RESET - 16'd1);
        push_step(1'b0, 1'b0, 1'b1, NEAR_LIMIT_RESET);
        push_step(1'b1, 1'b1, 1'b0, '0);
        push_step(1'b1, 1'b0, 1'b0, '0);
        push_step(1'b0, 1'b1, 1'b0, '0);
        push_step(1'b1, 1'b1, 1'b0, '0);
        push_step(1'b1, 1'b1, 1'b0, '0);
        push_step(1'b0, 1'b0, 1'b1, '0);
        push_step(1'b1, 1'b1, 1'b1, 16'hFFFF);
        push_step(1'b1, 1'b1, 1'b0, '0);
        push_step(1'b1, 1'b1, 1'b0, '0);
        push_step(1'b1, 1'b0, 1'b0, '0);
        push_step(1'b0, 1'b1, 1'b0, '0);
        push_step(1'b1, 1'b1, 1'b0, '0);

        run_phase(IDLE_NONE, 20, NEAR_LIMIT_RESET, 350, 1'b0);
        run_phase(IDLE_SENDER, 32, 16'd0, 350, 1'b0);
        run_phase(IDLE_RECEIVER, 0, 16'hFFFF, 120, 1'b0);
        run_phase(IDLE_BOTH, 46, 16'($urandom_range(1000, 3000)), 350, 1'b0);
        run_phase(IDLE_NONE, 64, 16'($urandom_range(0, 4000)), 450, 1'b1);
        wait_drained();
        repeat (4) @(posedge clk);

        $display("%0d requests checked, %0d of them counting with no program; reached step %0d",
                 checked_n, PRE_STEPS, step_idx);
        $display("%0d results under obstacle hold, %0d field mismatches", holds_seen, err_cnt);
        if (err_cnt == 0 && expected_motion_q.size() == 0) begin
            $display("PASS encoder_motion_command_sequencer_unit");
        end else begin
            $display("FAIL encoder_motion_command_sequencer_unit");
        end
        $finish;
    end

endmodule
